### sv/ptc_pkg.sv
package ptc_pkg;

  localparam int unsigned CounterSlots = 64;

  localparam int unsigned IdxW   = (CounterSlots > 1) ? $clog2(CounterSlots) : 1;
  localparam int unsigned CntW   = $clog2(CounterSlots + 1);
  localparam int unsigned IdxInW = 6;
  localparam int unsigned CmpW   = (CntW > IdxInW) ? CntW : IdxInW;

  localparam int unsigned ThrW   = 31;
  localparam int unsigned ActW   = 7;
  localparam int unsigned DeltaW = 32;
  localparam int unsigned LocW   = 34;
  localparam int unsigned GlobW  = 64;
  localparam int unsigned CfgW   = 31;

  localparam logic [ThrW-1:0] ThrReset = ThrW'(1024);
  localparam logic [ActW-1:0] ActReset = '0;

  typedef enum logic {
    CfgThreshold = 1'b0,
    CfgActive    = 1'b1
  } cfg_idx_e;

  typedef enum logic {
    OpAdd  = 1'b0,
    OpSync = 1'b1
  } op_e;

  typedef enum logic [3:0] {
    StIdle = 4'b0001,
    StAdd  = 4'b0010,
    StSync = 4'b0100,
    StFin  = 4'b1000
  } state_e;

endpackage

### sv/ptc_ram.sv
module ptc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                                           clk_i,
  input  logic                                           we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0]   waddr_i,
  input  logic [Width-1:0]                               wdata_i,
  input  logic                                           re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0]   raddr_i,
  output logic [Width-1:0]                               rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### sv/partitioned_threshold_counter.sv
// Channel | Handshake               | Payload                                       | Dir
// --------+-------------------------+-----------------------------------------------+----
// request | in_valid_i/in_ready_o   | operation_i, counter_index_i, delta_i         | in
// result  | out_valid_o/out_ready_i | global_total_o, local_value_o, flushed_o      | out
// config  | cfg_we_i                | cfg_idx_i, cfg_data_i                         | in
//
// An add reads the counter memory when it is accepted, then updates and writes back
// the counter when it commits; the next request is taken on the following cycle.
// A sync reads each active counter in turn after the accept, clearing its valid bit
// and adding it to the global total, drains the last read, and then posts the result.
// Reset clears the global total and all counter valid bits; an invalid entry reads 0.
// The result sits in an output register; a new request is taken while it waits,
// and the block holds before committing if the previous result is still not taken.
module partitioned_threshold_counter (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic                           cfg_idx_i,
  input  logic [ptc_pkg::CfgW-1:0]       cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           operation_i,
  input  logic [ptc_pkg::IdxInW-1:0]     counter_index_i,
  input  logic signed [ptc_pkg::DeltaW-1:0] delta_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic signed [ptc_pkg::GlobW-1:0] global_total_o,
  output logic signed [ptc_pkg::LocW-1:0]  local_value_o,
  output logic                           flushed_o
);

  import ptc_pkg::*;

  state_e state_q, state_d;

  logic [ThrW-1:0] thr_q;
  logic [ActW-1:0] act_q;
  logic [CntW-1:0] limit;

  logic [IdxInW-1:0]       idx_q;
  logic signed [DeltaW-1:0] delta_q;

  logic [CounterSlots-1:0] vld_q, vld_d;
  logic                    vld_rd_q, vld_rd_d;
  logic [CntW-1:0]         cnt_q, cnt_d;
  logic                    pend_q, pend_d;

  logic [GlobW-1:0] glob_q, glob_d;

  logic             out_vld_q, out_vld_d;
  logic [GlobW-1:0] out_glob_q, out_glob_d;
  logic [LocW-1:0]  out_loc_q, out_loc_d;
  logic             out_fl_q, out_fl_d;

  logic             ram_we, ram_re;
  logic [IdxW-1:0]  ram_waddr, ram_raddr;
  logic [LocW-1:0]  ram_wdata, ram_rdata;

  logic               accept, out_free, active, do_flush, issue;
  logic signed [LocW-1:0] rd_val, cur, th_s;

  ptc_ram #(
    .Width (LocW),
    .Depth (CounterSlots)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    if (act_q == '0 || CmpW'(act_q) > CmpW'(CounterSlots)) begin
      limit = CntW'(CounterSlots);
    end else begin
      limit = CntW'(act_q);
    end
  end

  assign in_ready_o = (state_q == StIdle);
  assign accept     = in_valid_i && in_ready_o;
  assign out_free   = !out_vld_q || out_ready_i;

  assign rd_val   = vld_rd_q ? $signed(ram_rdata) : '0;
  assign cur      = rd_val + LocW'(delta_q);
  assign th_s     = $signed({{(LocW-ThrW){1'b0}}, thr_q});
  assign active   = CmpW'(idx_q) < CmpW'(limit);
  assign do_flush = (cur > th_s) || (cur < -th_s);
  assign issue    = cnt_q < limit;

  always_comb begin
    state_d    = state_q;
    vld_d      = vld_q;
    vld_rd_d   = vld_rd_q;
    cnt_d      = cnt_q;
    pend_d     = 1'b0;
    glob_d     = glob_q;
    out_vld_d  = out_vld_q && !out_ready_i;
    out_glob_d = out_glob_q;
    out_loc_d  = out_loc_q;
    out_fl_d   = out_fl_q;
    ram_we     = 1'b0;
    ram_waddr  = IdxW'(idx_q);
    ram_wdata  = cur;
    ram_re     = 1'b0;
    ram_raddr  = IdxW'(counter_index_i);
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          cnt_d = '0;
          if (op_e'(operation_i) == OpSync) begin
            state_d = StSync;
          end else begin
            ram_re   = 1'b1;
            vld_rd_d = vld_q[IdxW'(counter_index_i)];
            state_d  = StAdd;
          end
        end
      end
      StAdd: begin
        if (out_free) begin
          if (active) begin
            ram_we                 = 1'b1;
            ram_wdata              = do_flush ? '0 : cur;
            vld_d[IdxW'(idx_q)]    = 1'b1;
            if (do_flush) begin
              glob_d = glob_q + GlobW'(cur);
            end
          end
          out_vld_d  = 1'b1;
          out_glob_d = glob_d;
          out_loc_d  = (active && !do_flush) ? cur : '0;
          out_fl_d   = active && do_flush;
          state_d    = StIdle;
        end
      end
      StSync: begin
        if (pend_q) begin
          glob_d = glob_q + GlobW'(rd_val);
        end
        if (issue) begin
          ram_re                    = 1'b1;
          ram_raddr                 = cnt_q[IdxW-1:0];
          vld_rd_d                  = vld_q[cnt_q[IdxW-1:0]];
          vld_d[cnt_q[IdxW-1:0]]    = 1'b0;
          cnt_d                     = cnt_q + 1'b1;
          pend_d                    = 1'b1;
        end else if (!pend_q) begin
          state_d = StFin;
        end
      end
      StFin: begin
        if (out_free) begin
          out_vld_d  = 1'b1;
          out_glob_d = glob_q;
          out_loc_d  = '0;
          out_fl_d   = 1'b1;
          state_d    = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      thr_q     <= ThrReset;
      act_q     <= ActReset;
      vld_q     <= '0;
      vld_rd_q  <= 1'b0;
      cnt_q     <= '0;
      pend_q    <= 1'b0;
      glob_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      vld_q     <= vld_d;
      vld_rd_q  <= vld_rd_d;
      cnt_q     <= cnt_d;
      pend_q    <= pend_d;
      glob_q    <= glob_d;
      out_vld_q <= out_vld_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_idx_i))
          CfgThreshold: thr_q <= cfg_data_i[ThrW-1:0];
          CfgActive:    act_q <= cfg_data_i[ActW-1:0];
          default:      ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      idx_q   <= counter_index_i;
      delta_q <= delta_i;
    end
    out_glob_q <= out_glob_d;
    out_loc_q  <= out_loc_d;
    out_fl_q   <= out_fl_d;
  end

  assign out_valid_o    = out_vld_q;
  assign global_total_o = $signed(out_glob_q);
  assign local_value_o  = $signed(out_loc_q);
  assign flushed_o      = out_fl_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StSync) |-> (cnt_q <= limit))
    else $error("sync walk ran past active count");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !out_ready_i) |=> out_vld_q)
    else $error("pending result dropped");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == StAdd || state_q == StSync))
    else $error("accepted request not started");

  a_we_add: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == StAdd && out_free))
    else $error("counter write outside add commit");

  a_sync_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($past(state_q) == StFin && state_q == StIdle) |-> (out_vld_q && out_fl_q))
    else $error("sync result not flagged");

endmodule
